FILE: rtl/core/dnsq_pkg.sv
// Shared types, constants and byte tables for the DNS query builder.
// No dependencies; compiled first.
package dnsq_pkg;

  localparam int LBL_CNT_W        = 6;   // holds any label length up to 63
  localparam int MAX_LABEL_DEF    = 63;
  localparam int CMD_Q_DEPTH_DEF  = 2;
  localparam int HEADER_LEN       = 12;
  localparam int TRAILER_LEN      = 5;
  localparam int CFG_IDX_W        = 8;
  localparam int CFG_DATA_W       = 16;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_ID       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FLAGS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUESTION_TYPE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUESTION_CLASS = 8'd3;

  localparam logic [15:0] QUERY_ID_RST       = 16'h1234;
  localparam logic [7:0]  HEADER_FLAGS_RST   = 8'h01;
  localparam logic [15:0] QUESTION_TYPE_RST  = 16'd16;
  localparam logic [15:0] QUESTION_CLASS_RST = 16'd1;

  typedef enum logic [1:0] {
    OP_HEADER  = 2'd0,
    OP_NAME    = 2'd1,
    OP_TRAILER = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_LBL,
    CMD_TRL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [LBL_CNT_W-1:0]   cnt;
    logic                   ovf;
  } cmd_t;

  typedef struct packed {
    logic                   en;
    logic [LBL_CNT_W-1:0]   addr;
    logic [7:0]             data;
  } lbl_wr_t;

  typedef struct packed {
    logic [15:0] query_id;
    logic [7:0]  header_flags;
    logic [15:0] question_type;
    logic [15:0] question_class;
  } cfg_t;

  // Header byte positions that carry something other than zero
  localparam logic [3:0] HDR_ID_HI    = 4'd0;
  localparam logic [3:0] HDR_ID_LO    = 4'd1;
  localparam logic [3:0] HDR_FLAGS    = 4'd2;
  localparam logic [3:0] HDR_QDCNT_LO = 4'd5;

  function automatic logic [7:0] hdr_byte(logic [3:0] pos, cfg_t cfg);
    logic [7:0] b;
    case (pos)
      HDR_ID_HI:    b = cfg.query_id[15:8];
      HDR_ID_LO:    b = cfg.query_id[7:0];
      HDR_FLAGS:    b = cfg.header_flags;
      HDR_QDCNT_LO: b = 8'h01;
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

  // Root terminator, then type and class, high byte first
  function automatic logic [7:0] trl_byte(logic [2:0] pos, cfg_t cfg);
    logic [7:0] b;
    case (pos)
      3'd1:    b = cfg.question_type[15:8];
      3'd2:    b = cfg.question_type[7:0];
      3'd3:    b = cfg.question_class[15:8];
      3'd4:    b = cfg.question_class[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/dnsq_if.sv
// Channel interfaces for the DNS query builder: input, result, configuration.
// Depends on dnsq_pkg for widths.
interface dnsq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] name_char;
  logic       name_ends;
  modport source (output valid, opcode, name_char, name_ends, input ready);
  modport sink   (input valid, opcode, name_char, name_ends, output ready);
endinterface

interface dnsq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       packet_end;
  logic       label_overflow;
  modport source (output valid, out_byte, run_last, packet_end, label_overflow,
                  input ready);
  modport sink   (input valid, out_byte, run_last, packet_end, label_overflow,
                  output ready);
endinterface

interface dnsq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dnsq_pkg::CFG_IDX_W-1:0]  index;
  logic [dnsq_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/dnsq_cmd_fifo.sv
// Small command queue between the front and back ends.
// Depends on dnsq_pkg (cmd_t).
module dnsq_cmd_fifo #(
  parameter int DEPTH = dnsq_pkg::CMD_Q_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dnsq_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output dnsq_pkg::cmd_t  pop_data,
  output logic            not_empty
);
  import dnsq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

FILE: rtl/core/dnsq_front.sv
// Front end: accepts input requests, tracks the current label and queues commands.
// Depends on dnsq_pkg and dnsq_in_if.
module dnsq_front #(
  parameter int MAX_LABEL = dnsq_pkg::MAX_LABEL_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  dnsq_in_if.sink            in_if,
  input  logic               q_full,
  output logic               q_push,
  output dnsq_pkg::cmd_t     q_data,
  output dnsq_pkg::lbl_wr_t  lbl_wr,
  input  logic               lbl_done
);
  import dnsq_pkg::*;

  logic [LBL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 lbl_busy_r;   // a label command is queued or being sent
  logic                 acc, is_dot, room;
  opcode_t              op;

  // Label store is read by the back end while a label is out, so hold off then
  assign in_if.ready = !q_full && !lbl_busy_r;
  assign acc    = in_if.valid && in_if.ready;
  assign op     = opcode_t'(in_if.opcode);
  assign is_dot = (in_if.name_char == DOT_CHAR);
  assign room   = (cnt_r < LBL_CNT_W'(MAX_LABEL));

  always_comb begin
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    q_push      = 1'b0;
    q_data      = '{kind: CMD_HDR, cnt: '0, ovf: 1'b0};
    lbl_wr.en   = 1'b0;
    lbl_wr.addr = cnt_r;
    lbl_wr.data = in_if.name_char;
    if (acc) begin
      case (op)
        OP_HEADER: begin
          q_push  = 1'b1;
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
        OP_NAME: begin
          if (is_dot) begin
            q_push  = 1'b1;
            q_data  = '{kind: CMD_LBL, cnt: cnt_r, ovf: ovf_r};
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end else begin
            if (room) begin
              lbl_wr.en = 1'b1;
              cnt_nxt   = cnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_if.name_ends) begin
              q_push  = 1'b1;
              q_data  = '{kind: CMD_LBL, cnt: cnt_nxt, ovf: ovf_nxt};
              cnt_nxt = '0;
              ovf_nxt = 1'b0;
            end
          end
        end
        OP_TRAILER: begin
          q_push  = 1'b1;
          q_data  = '{kind: CMD_TRL, cnt: '0, ovf: 1'b0};
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      lbl_busy_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      if (q_push && q_data.kind == CMD_LBL) lbl_busy_r <= 1'b1;
      else if (lbl_done)                     lbl_busy_r <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/dnsq_back.sv
// Back end: label store and byte sequencer feeding the registered result stage.
// Depends on dnsq_pkg and dnsq_out_if.
module dnsq_back #(
  parameter int MAX_LABEL = dnsq_pkg::MAX_LABEL_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dnsq_pkg::cfg_t     cfg,
  input  dnsq_pkg::lbl_wr_t  lbl_wr,
  input  logic               q_valid,
  input  dnsq_pkg::cmd_t     q_data,
  output logic               q_pop,
  output logic               lbl_done,
  dnsq_out_if.source         out_if
);
  import dnsq_pkg::*;

  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  typedef enum logic [1:0] {S_IDLE, S_HDR, S_LBL, S_TRL} state_t;

  state_t               state_r;
  logic [LBL_CNT_W-1:0] idx_r;
  logic [LBL_CNT_W-1:0] cnt_r;
  logic                 ovf_r;

  logic [7:0]           mem [MAX_LABEL];
  logic [7:0]           rd_data_r;
  logic                 rd_en;

  logic                 out_valid_r;
  logic [7:0]           byte_r;
  logic                 last_r, pend_r, lovf_r;

  logic                 out_ld, lbl_last, hdr_last, trl_last;

  assign out_ld   = !out_valid_r || out_if.ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  // idx 0 is the length byte; idx k sends label byte k-1 and fetches byte k
  assign lbl_last = (idx_r == cnt_r);
  assign hdr_last = (idx_r == LBL_CNT_W'(HEADER_LEN - 1));
  assign trl_last = (idx_r == LBL_CNT_W'(TRAILER_LEN - 1));
  assign rd_en    = (state_r == S_LBL) && out_ld && !lbl_last;
  assign lbl_done = (state_r == S_LBL) && out_ld && lbl_last;

  assign out_if.valid          = out_valid_r;
  assign out_if.out_byte       = byte_r;
  assign out_if.run_last       = last_r;
  assign out_if.packet_end     = pend_r;
  assign out_if.label_overflow = lovf_r;

  always_ff @(posedge clk) begin
    if (lbl_wr.en) mem[lbl_wr.addr[AW-1:0]] <= lbl_wr.data;
    if (rd_en)     rd_data_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // busy states reload the result stage whenever it drains
      if (out_if.ready && state_r == S_IDLE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            idx_r <= '0;
            cnt_r <= q_data.cnt;
            ovf_r <= q_data.ovf;
            case (q_data.kind)
              CMD_HDR: state_r <= S_HDR;
              CMD_LBL: state_r <= S_LBL;
              default: state_r <= S_TRL;
            endcase
          end
        end
        S_HDR: begin
          if (out_ld) begin
            out_valid_r <= 1'b1;
            byte_r      <= hdr_byte(idx_r[3:0], cfg);
            last_r      <= hdr_last;
            pend_r      <= 1'b0;
            lovf_r      <= 1'b0;
            if (hdr_last) state_r <= S_IDLE;
            else          idx_r   <= idx_r + 1'b1;
          end
        end
        S_LBL: begin
          if (out_ld) begin
            out_valid_r <= 1'b1;
            byte_r      <= (idx_r == '0) ? {{(8 - LBL_CNT_W){1'b0}}, cnt_r} : rd_data_r;
            last_r      <= lbl_last;
            pend_r      <= 1'b0;
            lovf_r      <= ovf_r;
            if (lbl_last) state_r <= S_IDLE;
            else          idx_r   <= idx_r + 1'b1;
          end
        end
        S_TRL: begin
          if (out_ld) begin
            out_valid_r <= 1'b1;
            byte_r      <= trl_byte(idx_r[2:0], cfg);
            last_r      <= trl_last;
            pend_r      <= trl_last;
            lovf_r      <= 1'b0;
            if (trl_last) state_r <= S_IDLE;
            else          idx_r   <= idx_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/dns_query_builder.sv
// Channel     | Dir | Payload                                         | Handshake
// in_if       | in  | opcode, name_char, name_ends                    | valid/ready
// out_if      | out | out_byte, run_last, packet_end, label_overflow  | valid/ready
// cfg_if      | in  | index, data                                     | valid/ready (ready=1)
//
// Name characters are taken one per cycle unless input stalls. The back end pops
// a command, then sends its bytes one a cycle while out_if is ready.
// Input stalls while a label is queued or being sent (the back end reads the
// label store then) and when the command queue is full.
// Synchronous active-low reset; the label store needs no clearing pass.
// Top level: configuration registers, front end, command queue, back end.
// Depends on dnsq_pkg, dnsq_if, dnsq_cmd_fifo, dnsq_front, dnsq_back.
module dns_query_builder #(
  parameter int MAX_LABEL   = dnsq_pkg::MAX_LABEL_DEF,
  parameter int CMD_Q_DEPTH = dnsq_pkg::CMD_Q_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dnsq_in_if.sink    in_if,
  dnsq_out_if.source out_if,
  dnsq_cfg_if.sink   cfg_if
);
  import dnsq_pkg::*;

  cfg_t    cfg_r;
  logic    q_push, q_full, q_pop, q_valid, lbl_done;
  cmd_t    q_in, q_out;
  lbl_wr_t lbl_wr;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.query_id       <= QUERY_ID_RST;
      cfg_r.header_flags   <= HEADER_FLAGS_RST;
      cfg_r.question_type  <= QUESTION_TYPE_RST;
      cfg_r.question_class <= QUESTION_CLASS_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_QUERY_ID:       cfg_r.query_id       <= cfg_if.data;
        REG_HEADER_FLAGS:   cfg_r.header_flags   <= cfg_if.data[7:0];
        REG_QUESTION_TYPE:  cfg_r.question_type  <= cfg_if.data;
        REG_QUESTION_CLASS: cfg_r.question_class <= cfg_if.data;
        default: ;
      endcase
    end
  end

  dnsq_front #(.MAX_LABEL(MAX_LABEL)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in),
    .lbl_wr   (lbl_wr),
    .lbl_done (lbl_done)
  );

  dnsq_cmd_fifo #(.DEPTH(CMD_Q_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  dnsq_back #(.MAX_LABEL(MAX_LABEL)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .lbl_wr   (lbl_wr),
    .q_valid  (q_valid),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .lbl_done (lbl_done),
    .out_if   (out_if)
  );

endmodule
